// ----- rtl/stuffed_frame_receiver_crc16_macros.svh -----
// Assertion macros for the stuffed frame receiver.
// Used by the top level; the macros expect signals named clk and rst in scope.
`ifndef STUFFED_FRAME_RECEIVER_CRC16_MACROS_SVH
`define STUFFED_FRAME_RECEIVER_CRC16_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sfr_pkg.sv -----
// Shared types, codes and the CRC16 byte update for the stuffed frame receiver.
// No dependencies; every other file but the macro header uses this package.
`timescale 1ns / 1ps

package sfr_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_BYTE     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OWN_ADDRESS    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CRC_POLYNOMIAL = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CRC_SEED       = 3'd3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [7:0]  FRAME_BYTE_RESET  = 8'd2;
  localparam logic [7:0]  OWN_ADDRESS_RESET = 8'd1;
  localparam logic [15:0] CRC_POLY_RESET    = 16'd4129;
  localparam logic [15:0] CRC_SEED_RESET    = 16'hFFFF;

  // Frame length bookkeeping: start, address, length and two CRC bytes.
  localparam logic [8:0] LEN_OVERHEAD = 9'd5;
  localparam logic [8:0] LEN_UNKNOWN  = 9'd255;

  localparam int unsigned QUEUE_DEPTH = 2;

  // Operations handed from the front to the back.
  localparam logic [2:0] OP_SEED    = 3'd0;
  localparam logic [2:0] OP_ADDR    = 3'd1;
  localparam logic [2:0] OP_CRC     = 3'd2;
  localparam logic [2:0] OP_PAYLOAD = 3'd3;
  localparam logic [2:0] OP_CRC_LO  = 3'd4;
  localparam logic [2:0] OP_END     = 3'd5;
  localparam logic [2:0] OP_RESTART = 3'd6;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ADDRESS  = 2'd1;
  localparam logic [1:0] ST_CRC      = 2'd2;
  localparam logic [1:0] ST_ABORTED  = 2'd3;

  typedef struct packed {
    logic [7:0]  frame_byte;
    logic [7:0]  own_address;
    logic [15:0] crc_polynomial;
    logic [15:0] crc_seed;
  } cfg_t;

  typedef struct packed {
    logic [7:0] byte_in;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [1:0] frame_status;
    logic       sync_bit;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data;
  } op_t;

  // One byte through an MSB-first CRC16, all eight shifts unrolled.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b,
                                             input logic [15:0] poly);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int j = 0; j < 8; j++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ poly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/sfr_if.sv -----
// Valid/ready stream interfaces for received bytes and for result items.
// Depends on sfr_pkg for the payload types.
`timescale 1ns / 1ps

interface sfr_byte_if;
  logic              valid;
  logic              ready;
  sfr_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sfr_result_if;
  logic               valid;
  logic               ready;
  sfr_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/sfr_front.sv -----
// Front end: takes raw bytes, removes doubled frame bytes, tracks the frame
// position and length and classifies each stored byte. Depends on sfr_pkg, sfr_if.
`timescale 1ns / 1ps

module sfr_front (
  input  logic          clk,
  input  logic          rst,
  input  sfr_pkg::cfg_t cfg,
  sfr_byte_if.sink      bytes,
  input  logic          q_full,
  output logic          q_push,
  output sfr_pkg::op_t  q_entry
);
  import sfr_pkg::*;

  logic [8:0] position;
  logic [8:0] position_next;
  logic [8:0] frame_length;
  logic [8:0] frame_length_next;
  logic       escape_pending;
  logic       escape_pending_next;

  logic       accept;
  logic       is_fb;
  logic       store;
  logic       restart;
  logic [9:0] pos_plus1;
  logic [9:0] pos_plus2;
  logic [7:0] b;

  assign bytes.ready = !q_full;
  assign accept      = bytes.valid && bytes.ready;
  assign b           = bytes.data.byte_in;
  assign is_fb       = (b == cfg.frame_byte);
  assign pos_plus1   = {1'b0, position} + 10'd1;
  assign pos_plus2   = {1'b0, position} + 10'd2;

  always_comb begin
    position_next       = position;
    frame_length_next   = frame_length;
    escape_pending_next = escape_pending;
    store               = 1'b0;
    restart             = 1'b0;
    q_push              = 1'b0;
    q_entry.op          = OP_SEED;
    q_entry.data        = b;

    if (accept) begin
      // A frame byte opens a frame directly; elsewhere it must come doubled.
      priority if (position == 9'd0 && is_fb) begin
        store = 1'b1;
      end else if (escape_pending) begin
        escape_pending_next = 1'b0;
        if (is_fb) begin
          store = 1'b1;
        end else begin
          restart = 1'b1;
        end
      end else if (is_fb) begin
        escape_pending_next = 1'b1;
      end else begin
        store = 1'b1;
      end

      if (restart) begin
        q_push            = 1'b1;
        q_entry.op        = OP_RESTART;
        position_next     = 9'd2;
        frame_length_next = LEN_UNKNOWN;
      end

      if (store) begin
        q_push = 1'b1;
        priority if (position == 9'd0) begin
          q_entry.op = OP_SEED;
        end else if (position == 9'd1) begin
          q_entry.op = OP_ADDR;
        end else if (position == 9'd2) begin
          q_entry.op = OP_CRC;
        end else if (pos_plus1 == {1'b0, frame_length}) begin
          q_entry.op = OP_END;
        end else if (pos_plus2 < {1'b0, frame_length}) begin
          q_entry.op = OP_PAYLOAD;
        end else begin
          q_entry.op = OP_CRC_LO;
        end

        if (q_entry.op == OP_END) begin
          position_next       = 9'd0;
          frame_length_next   = LEN_UNKNOWN;
          escape_pending_next = 1'b0;
        end else begin
          position_next = position + 9'd1;
          if (position == 9'd2) begin
            frame_length_next = {1'b0, b} + LEN_OVERHEAD;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position       <= 9'd0;
      frame_length   <= LEN_UNKNOWN;
      escape_pending <= 1'b0;
    end else begin
      position       <= position_next;
      frame_length   <= frame_length_next;
      escape_pending <= escape_pending_next;
    end
  end

endmodule

// ----- rtl/sfr_queue.sv -----
// Short register FIFO of classified operations between front and back.
// Depends on sfr_pkg for the entry type.
`timescale 1ns / 1ps

module sfr_queue #(
  parameter int unsigned Depth = sfr_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  sfr_pkg::op_t push_entry,
  input  logic         pop,
  output sfr_pkg::op_t head,
  output logic         empty,
  output logic         full
);
  import sfr_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  op_t            entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CntW'(Depth));
  assign head  = entries[rd_ptr];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    if (p == PtrW'(Depth - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/sfr_back.sv -----
// Back end: runs the CRC, holds address and CRC low byte, checks the frame at
// its end and drives the registered result stage. Depends on sfr_pkg, sfr_if.
`timescale 1ns / 1ps

module sfr_back (
  input  logic          clk,
  input  logic          rst,
  input  sfr_pkg::cfg_t cfg,
  input  sfr_pkg::op_t  q_head,
  input  logic          q_empty,
  output logic          q_pop,
  sfr_result_if.source  results
);
  import sfr_pkg::*;

  logic [15:0] running_crc;
  logic [7:0]  address_hold;
  logic [7:0]  crc_low_hold;
  logic        out_valid;
  out_item_t   out_data;

  logic        emits;
  logic        out_free;
  logic [15:0] crc_base;
  logic [15:0] crc_next;
  logic [1:0]  end_status;

  assign results.valid = out_valid;
  assign results.data  = out_data;

  always_comb begin
    unique case (q_head.op)
      OP_PAYLOAD, OP_END, OP_RESTART: emits = 1'b1;
      default:                        emits = 1'b0;
    endcase
  end

  assign out_free = !out_valid || results.ready;
  assign q_pop    = !q_empty && (!emits || out_free);

  // A restart folds its address byte into a fresh seed.
  assign crc_base = (q_head.op == OP_RESTART) ? cfg.crc_seed : running_crc;
  assign crc_next = crc16_byte(crc_base, q_head.data, cfg.crc_polynomial);

  always_comb begin
    priority if ((address_hold & cfg.frame_byte) != cfg.own_address) begin
      end_status = ST_ADDRESS;
    end else if (running_crc[7:0] != crc_low_hold || running_crc[15:8] != q_head.data) begin
      end_status = ST_CRC;
    end else begin
      end_status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      unique case (q_head.op)
        OP_SEED: begin
          running_crc <= cfg.crc_seed;
        end
        OP_ADDR, OP_RESTART: begin
          running_crc  <= crc_next;
          address_hold <= q_head.data;
        end
        OP_CRC, OP_PAYLOAD: begin
          running_crc <= crc_next;
        end
        OP_CRC_LO: begin
          crc_low_hold <= q_head.data;
        end
        default: begin
        end
      endcase

      if (emits) begin
        unique case (q_head.op)
          OP_PAYLOAD: begin
            out_data.kind         <= KIND_PAYLOAD;
            out_data.payload_byte <= q_head.data;
            out_data.frame_status <= ST_OK;
            out_data.sync_bit     <= 1'b0;
            out_data.last         <= 1'b0;
          end
          OP_END: begin
            out_data.kind         <= KIND_STATUS;
            out_data.payload_byte <= 8'd0;
            out_data.frame_status <= end_status;
            out_data.sync_bit     <= address_hold[7];
            out_data.last         <= 1'b1;
          end
          default: begin
            out_data.kind         <= KIND_STATUS;
            out_data.payload_byte <= 8'd0;
            out_data.frame_status <= ST_ABORTED;
            out_data.sync_bit     <= 1'b0;
            out_data.last         <= 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && emits) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/stuffed_frame_receiver_crc16.sv -----
// Result valid rises once the byte that causes it has been written into the queue
// at its transfer and the back end has then loaded the result register.
// Throughput: one byte per cycle while results are taken; the CRC16 update is unrolled.
// A stalled result side fills the QueueDepth-entry queue, after which bytes are held off.
// Reset (synchronous, active high) clears framing state, queue and result valid,
// and sets the configuration registers to their defaults; no clearing pass.
`timescale 1ns / 1ps
`include "stuffed_frame_receiver_crc16_macros.svh"

module stuffed_frame_receiver_crc16 #(
  parameter int unsigned QueueDepth = sfr_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [sfr_pkg::CFG_INDEX_W-1:0]  wr_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]   wr_data,
  sfr_byte_if.sink                         bytes,
  sfr_result_if.source                     results
);
  import sfr_pkg::*;

  cfg_t cfg;
  logic q_push;
  logic q_pop;
  logic q_empty;
  logic q_full;
  op_t  q_entry;
  op_t  q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_byte     <= FRAME_BYTE_RESET;
      cfg.own_address    <= OWN_ADDRESS_RESET;
      cfg.crc_polynomial <= CRC_POLY_RESET;
      cfg.crc_seed       <= CRC_SEED_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_FRAME_BYTE:     cfg.frame_byte     <= wr_data[7:0];
        REG_OWN_ADDRESS:    cfg.own_address    <= wr_data[7:0];
        REG_CRC_POLYNOMIAL: cfg.crc_polynomial <= wr_data[15:0];
        REG_CRC_SEED:       cfg.crc_seed       <= wr_data[15:0];
        default: begin
        end
      endcase
    end
  end

  sfr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .bytes   (bytes),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  sfr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty),
    .full       (q_full)
  );

  sfr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_head  (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .results (results)
  );

  `SFR_ASSERT_IMP(a_queue_no_overflow, q_push, !q_full || q_pop, "queue written while full")
  `SFR_ASSERT_IMP(a_no_pop_when_empty, q_pop, !q_empty, "queue read while empty")
  `SFR_ASSERT_IMP(a_last_marks_status, results.valid,
                  results.data.last == results.data.kind, "last does not match kind")
  `SFR_ASSERT_IMP(a_clear_after_reset, $fell(rst), !results.valid, "result valid just after reset")
  `SFR_ASSERT_NEXT(a_result_held, results.valid && !results.ready,
                   results.valid && $stable(results.data), "result changed while stalled")

endmodule

// ----- verif/tb_stuffed_frame_receiver_crc16.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the byte-stuffed frame receiver with CRC16 check.
// Needs sfr_pkg, the stream interfaces of sfr_if.sv and the top level RTL.

module tb_stuffed_frame_receiver_crc16;
  import sfr_pkg::*;

  typedef enum int {CRC_GOOD, CRC_FLIP_LOW, CRC_HIGH_IS_FB, CRC_LOW_IS_FB} crc_fault_t;

  // Follows the framing state of the receiver and holds the results it still owes.
  class frame_tracker;
    logic [7:0]  frame_byte;
    logic [7:0]  own_address;
    logic [15:0] poly;
    logic [15:0] seed;
    logic [8:0]  pos;
    logic [8:0]  flen;
    logic        esc;
    logic [15:0] crc;
    logic [7:0]  addr_hold;
    logic [7:0]  crc_lo;
    out_item_t   owed[$];
    int          failures;
    int          payload_count;
    int          status_count[4];

    function new();
      frame_byte    = FRAME_BYTE_RESET;
      own_address   = OWN_ADDRESS_RESET;
      poly          = CRC_POLY_RESET;
      seed          = CRC_SEED_RESET;
      pos           = '0;
      flen          = LEN_UNKNOWN;
      esc           = 1'b0;
      crc           = '0;
      addr_hold     = '0;
      crc_lo        = '0;
      failures      = 0;
      payload_count = 0;
      foreach (status_count[i]) status_count[i] = 0;
    endfunction

    function void set_reg(input logic [CFG_INDEX_W-1:0] idx,
                          input logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_FRAME_BYTE:     frame_byte = value[7:0];
        REG_OWN_ADDRESS:    own_address = value[7:0];
        REG_CRC_POLYNOMIAL: poly = value;
        REG_CRC_SEED:       seed = value;
        default: ;
      endcase
    endfunction

    function logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {b, 8'h00};
      for (int j = 0; j < 8; j++) r = r[15] ? ({r[14:0], 1'b0} ^ poly) : {r[14:0], 1'b0};
      return r;
    endfunction

    function void owe(input logic kind, input logic [7:0] pay, input logic [1:0] st,
                      input logic sync);
      out_item_t r;
      r.kind         = kind;
      r.payload_byte = pay;
      r.frame_status = st;
      r.sync_bit     = sync;
      r.last         = kind;
      owed.push_back(r);
    endfunction

    // One destuffed byte enters the frame at the current position.
    function void store(input logic [7:0] b);
      int         p;
      logic [1:0] st;
      p = pos;
      if (p == 0) begin
        crc = seed;
      end else if (p == 1) begin
        addr_hold = b;
        crc = crc_step(crc, b);
      end else if (p == 2) begin
        crc = crc_step(crc, b);
      end else if (p + 2 < flen) begin
        crc = crc_step(crc, b);
        owe(KIND_PAYLOAD, b, ST_OK, 1'b0);
      end else if (p + 2 == flen) begin
        crc_lo = b;
      end
      pos = pos + 9'd1;
      if (pos == 9'd3) flen = {1'b0, b} + LEN_OVERHEAD;
      if (pos == flen) begin
        if ((addr_hold & frame_byte) != own_address) st = ST_ADDRESS;
        else if (crc != {b, crc_lo}) st = ST_CRC;
        else st = ST_OK;
        owe(KIND_STATUS, 8'h00, st, addr_hold[7]);
        pos  = '0;
        flen = LEN_UNKNOWN;
        esc  = 1'b0;
      end
    endfunction

    function void take_byte(input logic [7:0] b);
      logic is_fb;
      is_fb = (b == frame_byte);
      if (pos == 0 && is_fb) begin
        store(b);
      end else if (esc) begin
        esc = 1'b0;
        if (!is_fb) begin
          // A lone frame byte followed by anything else aborts and reopens the frame.
          owe(KIND_STATUS, 8'h00, ST_ABORTED, 1'b0);
          crc       = crc_step(seed, b);
          addr_hold = b;
          pos       = 9'd2;
          flen      = LEN_UNKNOWN;
        end else begin
          store(b);
        end
      end else if (is_fb) begin
        esc = 1'b1;
      end else begin
        store(b);
      end
    endfunction

    function void check_result(input out_item_t got);
      out_item_t want;
      if (owed.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: kind %0d byte %02h status %0d sync %0d last %0d",
                   got.kind, got.payload_byte, got.frame_status, got.sync_bit, got.last);
        return;
      end
      want = owed.pop_front();
      if (want.kind == KIND_PAYLOAD) payload_count++;
      else status_count[want.frame_status]++;
      if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
          got.frame_status !== want.frame_status || got.sync_bit !== want.sync_bit ||
          got.last !== want.last) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: expected %0d/%02h/%0d/%0d/%0d, got %0d/%02h/%0d/%0d/%0d",
                   want.kind, want.payload_byte, want.frame_status, want.sync_bit,
                   want.last, got.kind, got.payload_byte, got.frame_status,
                   got.sync_bit, got.last);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   wr_en;
  logic [CFG_INDEX_W-1:0] wr_index;
  logic [CFG_DATA_W-1:0]  wr_data;

  sfr_byte_if   byte_ch ();
  sfr_result_if result_ch ();

  frame_tracker trk;
  int           burst_left = 0;
  bit           sending = 1'b0;
  int           bytes_sent = 0;
  int           settings_count = 0;
  logic [7:0]   payload_buf[$];

  stuffed_frame_receiver_crc16 u_dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .bytes    (byte_ch),
    .results  (result_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The receiver side rotates a random stall pattern that is itself swapped at random.
  initial begin
    logic [15:0] stall_pattern;
    int          stall_cycles;
    stall_cycles = 0;
    stall_pattern = 16'hFFFF;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_cycles == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pattern = 16'hFFFF;
          1:       stall_pattern = 16'($urandom) | 16'h0101;
          default: stall_pattern = 16'($urandom) | 16'($urandom) | 16'h0001;
        endcase
        stall_cycles = $urandom_range(50, 300);
      end
      stall_cycles--;
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      result_ch.ready <= stall_pattern[0];
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) trk.check_result(result_ch.data);
  end

  initial begin
    #(5_000_000);
    $display("Timed out waiting for the receiver.");
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      if (sending) begin
        byte_ch.valid <= 1'b0;
        sending = 1'b0;
      end
      gap = $urandom_range(1, 10);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.data  <= in_item_t'(b);
    sending = 1'b1;
    do @(posedge clk); while (!byte_ch.ready);
    burst_left--;
    bytes_sent++;
    trk.take_byte(b);
  endtask

  task automatic stop_sending();
    if (sending) begin
      byte_ch.valid <= 1'b0;
      sending = 1'b0;
    end
    burst_left = 0;
  endtask

  // Bytes that end in a lone frame byte or a length byte produce nothing, so the
  // pipeline is also let run on after the last owed result has arrived.
  task automatic wait_idle();
    stop_sending();
    while (trk.owed.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= value;
    @(posedge clk);
    trk.set_reg(idx, value);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] fb, input logic [7:0] own,
                           input logic [15:0] poly_v, input logic [15:0] seed_v);
    logic [CFG_INDEX_W-1:0] spare;
    // Upper bits of the narrow registers carry noise that must be dropped.
    write_reg(REG_FRAME_BYTE, {8'($urandom), fb});
    write_reg(REG_OWN_ADDRESS, {8'($urandom), own});
    write_reg(REG_CRC_POLYNOMIAL, poly_v);
    write_reg(REG_CRC_SEED, seed_v);
    spare = REG_CRC_SEED + CFG_INDEX_W'($urandom_range(1, 4));
    write_reg(spare, 16'($urandom));
    settings_count++;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0, 1:    return trk.frame_byte;
      2:       return 8'h00;
      3:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Sends a frame carrying payload_buf, or its first cut bytes. When the receiver
  // is part way through a frame, the new one is entered through a restart.
  task automatic send_frame(input logic [7:0] addr_in, input crc_fault_t fault,
                            input int cut);
    logic [7:0]  fb;
    logic [7:0]  addr;
    logic [7:0]  body[$];
    logic [7:0]  line_bytes[$];
    logic [15:0] c;
    logic [7:0]  lo;
    logic [7:0]  hi;
    bit          via_restart;
    fb = trk.frame_byte;
    addr = addr_in;
    via_restart = (trk.pos != 0);
    if (via_restart && addr == fb) addr = ~fb;
    body.push_back(addr);
    body.push_back(8'(payload_buf.size()));
    foreach (payload_buf[i]) body.push_back(payload_buf[i]);
    c = trk.seed;
    foreach (body[i]) c = trk.crc_step(c, body[i]);
    lo = c[7:0];
    hi = c[15:8];
    case (fault)
      CRC_FLIP_LOW:   lo = lo ^ 8'($urandom_range(1, 255));
      CRC_HIGH_IS_FB: hi = (hi == fb) ? ~hi : fb;
      CRC_LOW_IS_FB:  lo = (lo == fb) ? ~lo : fb;
      default: ;
    endcase
    body.push_back(lo);
    body.push_back(hi);
    if (!via_restart || !trk.esc) line_bytes.push_back(fb);
    foreach (body[i]) begin
      line_bytes.push_back(body[i]);
      if (body[i] == fb && !(via_restart && i == 0)) line_bytes.push_back(fb);
    end
    if (cut < 0 || cut > line_bytes.size()) cut = line_bytes.size();
    for (int i = 0; i < cut; i++) send_byte(line_bytes[i]);
  endtask

  task automatic random_frame(input int cut);
    logic [7:0] fb;
    logic [7:0] addr;
    int         len;
    int         roll;
    crc_fault_t fault;
    fb = trk.frame_byte;
    if ((trk.own_address & ~fb) == 8'h00 && $urandom_range(0, 3) != 0)
      addr = trk.own_address | (8'($urandom) & ~fb);
    else
      addr = 8'($urandom);
    roll = $urandom_range(0, 39);
    if (roll == 0) len = $urandom_range(0, 255);
    else if (roll < 5 && fb <= 8'd16) len = fb;
    else len = $urandom_range(0, 8);
    payload_buf.delete();
    repeat (len) payload_buf.push_back(pick_byte());
    case ($urandom_range(0, 11))
      0:       fault = CRC_FLIP_LOW;
      1:       fault = CRC_HIGH_IS_FB;
      2:       fault = CRC_LOW_IS_FB;
      default: fault = CRC_GOOD;
    endcase
    send_frame(addr, fault, cut);
  endtask

  // Mostly whole frames, with some broken off part way and some line noise.
  task automatic run_random(input int target);
    int stop_at;
    stop_at = bytes_sent + target;
    while (bytes_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0:       random_frame($urandom_range(1, 6));
        1:       repeat ($urandom_range(1, 6)) send_byte(pick_byte());
        default: random_frame(-1);
      endcase
    end
  endtask

  initial begin
    logic [7:0] fb;
    trk = new();
    rst           <= 1'b1;
    wr_en         <= 1'b0;
    wr_index      <= '0;
    wr_data       <= '0;
    byte_ch.valid <= 1'b0;
    byte_ch.data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    configure(8'h7E, 8'h02, 16'h1021, 16'hFFFF);
    payload_buf = '{8'h00, 8'h7E, 8'hFF};
    send_frame(8'h83, CRC_GOOD, -1);
    payload_buf.delete();
    send_frame(8'h02, CRC_FLIP_LOW, -1);
    send_frame(8'h41, CRC_FLIP_LOW, -1);
    send_frame(8'h02, CRC_GOOD, 2);
    send_frame(8'h02, CRC_GOOD, -1);
    run_random(150);

    wait_idle();
    configure(8'h00, 8'h00, 16'h0000, 16'h0000);
    run_random(180);
    wait_idle();
    configure(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    run_random(180);
    wait_idle();
    configure(FRAME_BYTE_RESET, OWN_ADDRESS_RESET, CRC_POLY_RESET, CRC_SEED_RESET);
    run_random(180);
    wait_idle();
    fb = 8'($urandom);
    configure(fb, 8'($urandom) & fb, 16'($urandom), 16'($urandom));
    run_random(180);
    wait_idle();
    configure(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
    run_random(180);
    wait_idle();
    repeat (12) @(posedge clk);

    $display("Sent %0d bytes under %0d register settings with stalls on both sides.",
             bytes_sent, settings_count);
    $display("Checked %0d payload bytes; statuses ok %0d, address %0d, CRC %0d, aborted %0d.",
             trk.payload_count, trk.status_count[ST_OK], trk.status_count[ST_ADDRESS],
             trk.status_count[ST_CRC], trk.status_count[ST_ABORTED]);
    if (trk.failures == 0 && trk.owed.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d failures, %0d results never arrived.", trk.failures, trk.owed.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
